>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the two-axis PID core. Empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked check, disabled while reset is asserted
`define TAPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tapc assertion failed");
// clocked check that also holds during reset
`define TAPC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tapc assertion failed");
`else
`define TAPC_ASSERT(label, clk, rst_n, prop)
`define TAPC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> rtl/core/tapc_pkg.sv
// ----------------------------------------------------------------------------
// tapc_pkg
// Shared types and constants of the two-axis PID core.
// ----------------------------------------------------------------------------
`default_nettype none

package tapc_pkg;

    localparam int DATA_W    = 16;
    localparam int ERR_W     = 17;
    localparam int DELTA_W   = 18;
    localparam int SUM_W     = 24;
    localparam int ACC_W     = 42;
    localparam int SHIFT     = 8;
    localparam int CFG_IDX_W = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN_X  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN_X = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN_Z  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN_Z = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN_Z = 4'd7;

    // error sum saturation bounds
    localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7fffff;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

    // output clamp, +-1.0 in Q14
    localparam logic signed [DATA_W-1:0] OUT_LIM   = 16'sd16384;
    localparam logic signed [DATA_W-1:0] OUT_LIM_N = -16'sd16384;

    // per-axis settings
    typedef struct packed {
        logic signed [DATA_W-1:0] target;
        logic signed [DATA_W-1:0] kp;
        logic signed [DATA_W-1:0] kd;
        logic signed [DATA_W-1:0] ki;
    } tapc_axis_cfg_t;

    // pipeline control from the top to each axis
    typedef struct packed {
        logic adv;   // all stages move one step
        logic upd;   // detected word leaves the input register: update state
    } tapc_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/tapc_if.sv
// ----------------------------------------------------------------------------
// tapc_if
// Valid/ready channels of the two-axis PID core: sample, command, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface tapc_in_if import tapc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     detected;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_z;

    modport source (output valid, output detected, output pos_x, output pos_z,
                    input ready);
    modport sink   (input valid, input detected, input pos_x, input pos_z,
                    output ready);
endinterface

interface tapc_out_if import tapc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] roll_cmd;
    logic signed [DATA_W-1:0] pitch_cmd;

    modport source (output valid, output roll_cmd, output pitch_cmd, input ready);
    modport sink   (input valid, input roll_cmd, input pitch_cmd, output ready);
endinterface

interface tapc_cfg_if import tapc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tapc_axis.sv
// ----------------------------------------------------------------------------
// tapc_axis
// One PID axis: error and saturating sum, three gain products, then
// combine, floor shift by 8 and clamp to +-16384.
// ----------------------------------------------------------------------------
`default_nettype none

module tapc_axis
    import tapc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tapc_ctrl_t               ctrl,
    input  wire tapc_axis_cfg_t           cfg,
    input  wire logic signed [DATA_W-1:0] pos,
    output logic signed [DATA_W-1:0]      cmd
);

    // axis state
    logic signed [SUM_W-1:0]   sum_reg,  sum_next;
    logic signed [ERR_W-1:0]   prev_reg;

    // stage 2: error terms
    logic signed [ERR_W-1:0]   err_reg,   err_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic signed [SUM_W-1:0]   isum_reg;

    // stage 3: products
    logic signed [32:0]        p_reg, p_next;
    logic signed [33:0]        d_reg, d_next;
    logic signed [39:0]        i_reg, i_next;

    logic signed [SUM_W:0]     sum_wide;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-SHIFT-1:0] acc_sh;

    // error, derivative difference and saturating sum
    always_comb
    begin
        err_next   = {pos[DATA_W-1], pos} - {cfg.target[DATA_W-1], cfg.target};
        delta_next = {prev_reg[ERR_W-1], prev_reg} - {err_next[ERR_W-1], err_next};
        sum_wide   = {sum_reg[SUM_W-1], sum_reg}
                   + {{(SUM_W-ERR_W+1){err_next[ERR_W-1]}}, err_next};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end
        else if (ctrl.upd)
        begin
            sum_reg  <= sum_next;
            prev_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            err_reg   <= err_next;
            delta_reg <= delta_next;
            isum_reg  <= sum_next;
        end
    end

    // gain products
    assign p_next = cfg.kp * err_reg;
    assign d_next = cfg.kd * delta_reg;
    assign i_next = cfg.ki * isum_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            p_reg <= p_next;
            d_reg <= d_next;
            i_reg <= i_next;
        end
    end

    // combine, floor shift, clamp
    always_comb
    begin
        acc = {{(ACC_W-33){p_reg[32]}}, p_reg}
            + {{(ACC_W-34){d_reg[33]}}, d_reg}
            + {{(ACC_W-40){i_reg[39]}}, i_reg};
        acc_sh = acc[ACC_W-1:SHIFT];
        if (acc_sh > OUT_LIM)
        begin
            cmd = OUT_LIM;
        end
        else if (acc_sh < OUT_LIM_N)
        begin
            cmd = OUT_LIM_N;
        end
        else
        begin
            cmd = acc_sh[DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/two_axis_pid_controller_core.sv
// ----------------------------------------------------------------------------
// two_axis_pid_controller_core
// Takes one sensor word per cycle while the command side does not stall and
// returns one command word per sensor word, which is valid once its sensor
// word has passed through all of the stages named below.
// Both axes are fully pipelined (input register, error/sum stage, gain
// product stage, output register), so the sustained rate is one word per
// cycle while the command side does not stall; the loop through the error
// sum and previous error registers is what limits that rate. A stall on the
// command side holds the whole pipeline. Configuration writes take effect at
// once and are meant to be issued only while the pipeline is empty. Words
// with detected low give zero commands and leave the error state untouched.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module two_axis_pid_controller_core
    import tapc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    tapc_in_if.sink   sample,
    tapc_out_if.source command,
    tapc_cfg_if.sink  cfg
);

    tapc_axis_cfg_t cfg_x_reg, cfg_z_reg;

    logic                     adv;
    tapc_ctrl_t               ctrl;

    logic                     s1_valid_reg, s1_det_reg;
    logic signed [DATA_W-1:0] s1_pos_x_reg, s1_pos_z_reg;
    logic                     s2_valid_reg, s2_det_reg;
    logic                     s3_valid_reg, s3_det_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] roll_reg, roll_next;
    logic signed [DATA_W-1:0] pitch_reg, pitch_next;
    logic signed [DATA_W-1:0] x_cmd, z_cmd;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_x_reg <= '0;
            cfg_z_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TARGET_X:     cfg_x_reg.target <= cfg.data;
                REG_TARGET_Z:     cfg_z_reg.target <= cfg.data;
                REG_PROP_GAIN_X:  cfg_x_reg.kp     <= cfg.data;
                REG_DERIV_GAIN_X: cfg_x_reg.kd     <= cfg.data;
                REG_INTEG_GAIN_X: cfg_x_reg.ki     <= cfg.data;
                REG_PROP_GAIN_Z:  cfg_z_reg.kp     <= cfg.data;
                REG_DERIV_GAIN_Z: cfg_z_reg.kd     <= cfg.data;
                REG_INTEG_GAIN_Z: cfg_z_reg.ki     <= cfg.data;
                default:          ;
            endcase
        end
    end

    // pipeline advance: output register empty or being drained
    assign adv          = !out_valid_reg || command.ready;
    assign sample.ready = adv;
    assign ctrl.adv     = adv;
    assign ctrl.upd     = adv && s1_valid_reg && s1_det_reg;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= sample.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // input register and detected flag through the stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_det_reg   <= sample.detected;
            s1_pos_x_reg <= sample.pos_x;
            s1_pos_z_reg <= sample.pos_z;
            s2_det_reg   <= s1_det_reg;
            s3_det_reg   <= s2_det_reg;
        end
    end

    tapc_axis u_axis_x (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cfg   (cfg_x_reg),
        .pos   (s1_pos_x_reg),
        .cmd   (x_cmd)
    );

    tapc_axis u_axis_z (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cfg   (cfg_z_reg),
        .pos   (s1_pos_z_reg),
        .cmd   (z_cmd)
    );

    // output register; pitch is the negated z command
    assign roll_next  = s3_det_reg ? x_cmd : '0;
    assign pitch_next = s3_det_reg ? -z_cmd : '0;

    always_ff @(posedge clk)
    begin
        if (adv && s3_valid_reg)
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
        end
    end

    assign command.valid     = out_valid_reg;
    assign command.roll_cmd  = roll_reg;
    assign command.pitch_cmd = pitch_reg;

    // checks
    `TAPC_ASSERT(a_roll_range, clk, rst_n, command.valid |-> (command.roll_cmd <= OUT_LIM && command.roll_cmd >= OUT_LIM_N))
    `TAPC_ASSERT(a_pitch_range, clk, rst_n, command.valid |-> (command.pitch_cmd <= OUT_LIM && command.pitch_cmd >= OUT_LIM_N))
    `TAPC_ASSERT(a_stall_holds, clk, rst_n, !adv |=> ($stable(s1_valid_reg) && $stable(s2_valid_reg) && $stable(s3_valid_reg)))
    `TAPC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!s1_valid_reg && !out_valid_reg))

endmodule

`default_nettype wire
